// ===== sv/uds_pkg.sv =====
// uds_pkg: shared types and constants of the diagnostic server
// no dependencies
package uds_pkg;

    localparam logic [7:0] SID_SESS_CTRL = 8'h10;
    localparam logic [7:0] SID_ECU_RST   = 8'h11;
    localparam logic [7:0] SID_DID     = 8'h22;
    localparam logic [7:0] SID_DTC     = 8'h19;
    localparam logic [7:0] SID_SEC     = 8'h27;
    localparam logic [7:0] SID_TPRESENT  = 8'h3E;
    localparam logic [7:0] POS_OFS     = 8'h40;
    localparam logic [7:0] NEG_SID     = 8'h7F;
    localparam logic [7:0] NRC_SUBFUNC = 8'h12;
    localparam logic [7:0] NRC_LENGTH  = 8'h13;
    localparam logic [7:0] NRC_COND    = 8'h22;
    localparam logic [7:0] NRC_RANGE   = 8'h31;
    localparam logic [15:0] KEY_XOR    = 16'h5555;

    localparam logic [2:0] REG_ECU     = 3'd0;
    localparam logic [2:0] REG_S3      = 3'd1;
    localparam logic [2:0] REG_ENG     = 3'd2;
    localparam logic [2:0] REG_VEH     = 3'd3;
    localparam logic [2:0] REG_COOL    = 3'd4;
    localparam logic [2:0] REG_THR     = 3'd5;
    localparam logic [2:0] REG_PED     = 3'd6;
    localparam logic [2:0] REG_INT     = 3'd7;

    localparam int DTC_N = 6;

    // response as a byte list, built by the front end
    typedef struct packed {
        logic [15:0][7:0] bytes;
        logic [4:0]       len;     // 1..16
        logic             empty;   // suppressed positive: one empty item
        logic             neg;
    } resp_t;

    function automatic logic [2:0] dtc_unit(input int i);
        case (i)
            3: dtc_unit = 3'd2;
            4: dtc_unit = 3'd4;
            5: dtc_unit = 3'd1;
            default: dtc_unit = 3'd0;
        endcase
    endfunction

    function automatic logic [23:0] dtc_code(input int i);
        case (i)
            0: dtc_code = 24'h000301;
            1: dtc_code = 24'h000420;
            2: dtc_code = 24'h000100;
            3: dtc_code = 24'h000035;
            4: dtc_code = 24'h001A00;
            default: dtc_code = 24'h000A7F;
        endcase
    endfunction

    function automatic logic [7:0] dtc_stat(input int i);
        case (i)
            1, 4: dtc_stat = 8'h04;
            2: dtc_stat = 8'h0B;
            default: dtc_stat = 8'h2B;
        endcase
    endfunction

endpackage

// ===== sv/uds_front.sv =====
// uds_front: accepts requests, keeps session state, builds the response bytes
// depends on uds_pkg
module uds_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       opcode,
    input  logic [7:0]       sub_byte,
    input  logic [1:0]       data_count,
    input  logic [7:0]       data_first,
    input  logic [7:0]       data_second,
    input  logic             suppress,
    input  logic [31:0]      now_ms,
    input  logic [15:0]      fresh_seed,
    input  logic [2:0]       ecu_select,
    input  logic [15:0]      s3_timeout_ms,
    input  logic [15:0]      engine_speed_raw,
    input  logic [15:0]      vehicle_speed_raw,
    input  logic [7:0]       coolant_temp_raw,
    input  logic [7:0]       throttle_raw,
    input  logic [7:0]       pedal_raw,
    input  logic [7:0]       intake_temp_raw,
    output logic             q_valid,
    input  logic             q_ready,
    output uds_pkg::resp_t   q_data
);
    // stage 0: register request and timeout flag; stage 1: build response
    logic        req_vld_reg;
    logic [7:0]  sid_reg, sub_reg, d0_reg, d1_reg;
    logic [1:0]  cnt_reg;
    logic        spr_reg;
    logic [31:0] now_reg;
    logic [15:0] seedin_reg;
    logic        timeout_reg;
    logic        out_vld_reg;
    uds_pkg::resp_t out_reg;

    logic [1:0]  session_reg, session_next;
    logic        unlocked_reg, unlocked_next;
    logic        pend_reg, pend_next;
    logic [15:0] seed_reg, seed_next;
    logic [31:0] last_reg, last_next;

    logic [31:0] elapsed;
    assign elapsed = now_ms - last_reg;
    assign in_ready = !req_vld_reg && !out_vld_reg;
    assign q_valid = out_vld_reg;
    assign q_data = out_reg;

    uds_pkg::resp_t r;
    logic [1:0] sess;
    logic perm;
    logic [7:0] act;
    logic [15:0] did, val;
    logic two, hit;
    logic [7:0] mask;
    logic [4:0] n;
    logic [23:0] code;

    always_comb begin
        r = '0;
        r.len = 5'd3;
        session_next = session_reg;
        unlocked_next = unlocked_reg;
        pend_next = pend_reg;
        seed_next = seed_reg;
        last_next = last_reg;
        sess = session_reg;
        act = {1'b0, sub_reg[6:0]};
        did = {d0_reg, d1_reg};
        val = '0;
        two = 1'b0;
        hit = 1'b1;
        mask = (cnt_reg != 2'd0) ? d0_reg : 8'hFF;
        n = '0;
        code = '0;
        perm = 1'b0;
        r.bytes[0] = uds_pkg::NEG_SID;
        r.bytes[1] = sid_reg;
        r.neg = 1'b1;
        if (sid_reg == uds_pkg::SID_TPRESENT) begin
            last_next = now_reg;
            r.neg = 1'b0;
            r.len = 5'd1;
            r.bytes[0] = uds_pkg::SID_TPRESENT + uds_pkg::POS_OFS;
        end else begin
            if (timeout_reg) begin
                sess = 2'd0;
                session_next = 2'd0;
                unlocked_next = 1'b0;
            end
            case (sess)
                2'd1: perm = sid_reg == uds_pkg::SID_SESS_CTRL || sid_reg == uds_pkg::SID_DID
                          || sid_reg == uds_pkg::SID_DTC || sid_reg == uds_pkg::SID_ECU_RST
                          || sid_reg == uds_pkg::SID_SEC;
                2'd2: perm = sid_reg == uds_pkg::SID_SESS_CTRL
                          || sid_reg == uds_pkg::SID_ECU_RST
                          || sid_reg == uds_pkg::SID_SEC;
                default: perm = sid_reg == uds_pkg::SID_SESS_CTRL
                          || sid_reg == uds_pkg::SID_DID || sid_reg == uds_pkg::SID_DTC;
            endcase
            r.bytes[2] = uds_pkg::NRC_COND;
            if (perm) begin
                case (sid_reg)
                    uds_pkg::SID_SESS_CTRL: begin
                        if (sub_reg == 8'd1 || sub_reg == 8'd2 || sub_reg == 8'd3) begin
                            session_next = (sub_reg == 8'd1) ? 2'd0 :
                                           (sub_reg == 8'd2) ? 2'd2 : 2'd1;
                            last_next = now_reg;
                            r.neg = 1'b0;
                            r.empty = spr_reg;
                            r.len = spr_reg ? 5'd1 : 5'd2;
                            r.bytes[0] = spr_reg ? 8'h00 : sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = sub_reg;
                        end else r.bytes[2] = uds_pkg::NRC_SUBFUNC;
                    end
                    uds_pkg::SID_ECU_RST: begin
                        if (sub_reg == 8'd1) begin
                            r.neg = 1'b0;
                            r.empty = spr_reg;
                            r.len = spr_reg ? 5'd1 : 5'd2;
                            r.bytes[0] = spr_reg ? 8'h00 : sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = 8'd1;
                        end else r.bytes[2] = uds_pkg::NRC_SUBFUNC;
                    end
                    uds_pkg::SID_DID: begin
                        case (did)
                            16'h000C: begin val = engine_speed_raw; two = 1'b1; end
                            16'h000D: begin val = vehicle_speed_raw; two = 1'b1; end
                            16'h0005: val = {8'h00, coolant_temp_raw};
                            16'h0011: val = {8'h00, throttle_raw};
                            16'h004C: val = {8'h00, pedal_raw};
                            16'h000F: val = {8'h00, intake_temp_raw};
                            default: hit = 1'b0;
                        endcase
                        if (cnt_reg == 2'd0 || cnt_reg == 2'd1) r.bytes[2] = uds_pkg::NRC_LENGTH;
                        else if (ecu_select != 3'd0 || !hit) r.bytes[2] = uds_pkg::NRC_RANGE;
                        else begin
                            r.neg = 1'b0;
                            r.bytes[0] = sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = d0_reg;
                            r.bytes[2] = d1_reg;
                            r.bytes[3] = two ? val[15:8] : val[7:0];
                            r.bytes[4] = val[7:0];
                            r.len = two ? 5'd5 : 5'd4;
                        end
                    end
                    uds_pkg::SID_DTC: begin
                        if (sub_reg == 8'h02) begin
                            r.neg = 1'b0;
                            r.bytes[0] = sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = 8'h02;
                            r.bytes[2] = 8'h01;
                            r.bytes[3] = 8'hFF;
                            n = 5'd4;
                            for (int i = 0; i < uds_pkg::DTC_N; i++) begin
                                code = uds_pkg::dtc_code(i);
                                if (uds_pkg::dtc_unit(i) == ecu_select
                                    && (uds_pkg::dtc_stat(i) & mask) != 8'h00
                                    && n <= 5'd12) begin
                                    r.bytes[n[3:0]]        = code[23:16];
                                    r.bytes[n[3:0] + 4'd1] = code[15:8];
                                    r.bytes[n[3:0] + 4'd2] = code[7:0];
                                    r.bytes[n[3:0] + 4'd3] = uds_pkg::dtc_stat(i);
                                    n = n + 5'd4;
                                end
                            end
                            r.len = n;
                        end else if (sub_reg == 8'h0A) begin
                            for (int i = 0; i < uds_pkg::DTC_N; i++)
                                if (uds_pkg::dtc_unit(i) == ecu_select) n = n + 5'd1;
                            r.neg = 1'b0;
                            r.bytes[0] = sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = 8'h0A;
                            r.bytes[2] = {3'd0, n};
                        end else r.bytes[2] = uds_pkg::NRC_SUBFUNC;
                    end
                    default: begin
                        if (act == 8'd1) begin
                            seed_next = seedin_reg;
                            pend_next = 1'b1;
                            r.neg = 1'b0;
                            r.empty = spr_reg;
                            r.len = spr_reg ? 5'd1 : 5'd4;
                            r.bytes[0] = spr_reg ? 8'h00 : sid_reg + uds_pkg::POS_OFS;
                            r.bytes[1] = 8'd1;
                            r.bytes[2] = seedin_reg[15:8];
                            r.bytes[3] = seedin_reg[7:0];
                        end else if (act == 8'd2) begin
                            if (!pend_reg) r.bytes[2] = uds_pkg::NRC_COND;
                            else if (cnt_reg == 2'd0 || cnt_reg == 2'd1)
                                r.bytes[2] = uds_pkg::NRC_LENGTH;
                            else if (did != (seed_reg ^ uds_pkg::KEY_XOR))
                                r.bytes[2] = uds_pkg::NRC_RANGE;
                            else begin
                                unlocked_next = 1'b1;
                                pend_next = 1'b0;
                                r.neg = 1'b0;
                                r.empty = spr_reg;
                                r.len = spr_reg ? 5'd1 : 5'd2;
                                r.bytes[0] = spr_reg ? 8'h00 : sid_reg + uds_pkg::POS_OFS;
                                r.bytes[1] = 8'd2;
                            end
                        end else r.bytes[2] = uds_pkg::NRC_SUBFUNC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            session_reg <= 2'd0;
            unlocked_reg <= 1'b0;
            pend_reg <= 1'b0;
            seed_reg <= '0;
            last_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                req_vld_reg <= 1'b1;
                sid_reg <= opcode;
                sub_reg <= sub_byte;
                cnt_reg <= (data_count == 2'd3) ? 2'd2 : data_count;
                d0_reg <= data_first;
                d1_reg <= data_second;
                spr_reg <= suppress;
                now_reg <= now_ms;
                seedin_reg <= fresh_seed;
                // session mode three counts as default
                timeout_reg <= (session_reg == 2'd1 || session_reg == 2'd2)
                               && elapsed > {16'h0000, s3_timeout_ms};
            end
            if (req_vld_reg) begin
                req_vld_reg <= 1'b0;
                out_vld_reg <= 1'b1;
                out_reg <= r;
                session_reg <= session_next;
                unlocked_reg <= unlocked_next;
                pend_reg <= pend_next;
                seed_reg <= seed_next;
                last_reg <= last_next;
            end
            if (out_vld_reg && q_ready) out_vld_reg <= 1'b0;
        end
    end

    a_one_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req_vld_reg && out_vld_reg)) else $error("front stages both busy");
    a_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_reg.len != 5'd0) else $error("empty response");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !q_ready |=> out_vld_reg) else $error("response lost");
endmodule

// ===== sv/uds_queue.sv =====
// uds_queue: two-entry queue of built responses between front and back
// depends on uds_pkg
module uds_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  uds_pkg::resp_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output uds_pkg::resp_t rd_data
);
    uds_pkg::resp_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;
    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg) else $error("pointer slip");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        wr && !rd |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count not advanced");
endmodule

// ===== sv/uds_back.sv =====
// uds_back: streams one queued response out a byte per item
// depends on uds_pkg
module uds_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  uds_pkg::resp_t q_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [1:0]     m_tuser
);
    logic [3:0] idx_reg;
    logic last;
    assign last = {1'b0, idx_reg} == q_data.len - 5'd1;
    assign m_tvalid = q_valid;
    assign m_tdata = q_data.bytes[idx_reg];
    assign m_tlast = last;
    assign m_tuser = {q_data.neg, !q_data.empty};
    assign q_ready = m_tready && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) idx_reg <= '0;
        else if (q_valid && m_tready) idx_reg <= last ? 4'd0 : idx_reg + 4'd1;
    end

    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> {1'b0, idx_reg} < q_data.len) else $error("index past response");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |=> idx_reg == 4'd0) else $error("index not rewound");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_data.empty |-> last) else $error("empty item not last");
endmodule

// ===== sv/uds_diagnostic_server_unit.sv =====
// uds_diagnostic_server_unit: top level of the diagnostic server
// depends on uds_pkg, uds_front, uds_queue, uds_back
//
// usage:
//  - s_ channel takes one request per item; m_ channel returns the response
//    as byte items, tlast on the final one, tuser = {negative, byte_valid}
//  - cfg channel writes the eight registers (index 0..7); the user must
//    write them only while idle, which the block does not enforce
//  - front: request registered, then the response is built from its fields
//    (session, timeout, permission, service) and pushed into a 2-deep queue
//  - the front takes a new request only once its last response is queued;
//    the back end sends one byte per cycle while m_tready is high
//  - stall on m_: the queue fills, then s_tready drops
//  - reset: registers at defaults, default session, locked, no seed
module uds_diagnostic_server_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[7:0], sub_function[15:8], data_count[17:16], data_first[25:18],
    // data_second[33:26], now_ms[65:34], fresh_seed[81:66], zeros[87:82]
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,    // suppress
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // resp_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // byte_valid[0], negative[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [2:0]  ecu_reg;
    logic [15:0] s3_reg, eng_reg, veh_reg;
    logic [7:0]  cool_reg, thr_reg, ped_reg, int_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecu_reg <= 3'd0;
            s3_reg <= 16'd5000;
            eng_reg <= 16'd800;
            veh_reg <= 16'd0;
            cool_reg <= 8'd130;
            thr_reg <= 8'd37;
            ped_reg <= 8'd50;
            int_reg <= 8'd75;
        end else if (cfg_valid) begin
            case (cfg_index)
                uds_pkg::REG_ECU:  ecu_reg <= cfg_data[2:0];
                uds_pkg::REG_S3:   s3_reg <= cfg_data;
                uds_pkg::REG_ENG:  eng_reg <= cfg_data;
                uds_pkg::REG_VEH:  veh_reg <= cfg_data;
                uds_pkg::REG_COOL: cool_reg <= cfg_data[7:0];
                uds_pkg::REG_THR:  thr_reg <= cfg_data[7:0];
                uds_pkg::REG_PED:  ped_reg <= cfg_data[7:0];
                uds_pkg::REG_INT:  int_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic           fq_valid, fq_ready, bq_valid, bq_ready;
    uds_pkg::resp_t fq_data, bq_data;

    // front: classify and build
    uds_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tdata[7:0]), .sub_byte(s_tdata[15:8]),
        .data_count(s_tdata[17:16]), .data_first(s_tdata[25:18]),
        .data_second(s_tdata[33:26]), .suppress(s_tuser),
        .now_ms(s_tdata[65:34]), .fresh_seed(s_tdata[81:66]),
        .ecu_select(ecu_reg), .s3_timeout_ms(s3_reg),
        .engine_speed_raw(eng_reg), .vehicle_speed_raw(veh_reg),
        .coolant_temp_raw(cool_reg), .throttle_raw(thr_reg),
        .pedal_raw(ped_reg), .intake_temp_raw(int_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    // queue between front and back
    uds_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
    );

    // back: serialize bytes
    uds_back u_back (
        .aclk, .aresetn,
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

    a_cfg_ecu: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == uds_pkg::REG_ECU |=> ecu_reg == $past(cfg_data[2:0]))
        else $error("ecu select not written");
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1]) else $error("bad empty item");
    a_neg_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0]) else $error("negative without byte");
endmodule
